### hdl/tbcd_pkg.sv
// Shared types and constants for the TBCD user-to-user number decoder.
package tbcd_pkg;

  typedef enum logic [3:0] {
    PH_P0    = 4'd0,
    PH_P1    = 4'd1,
    PH_REC   = 4'd2,
    PH_SKIP  = 4'd3,
    PH_VAL   = 4'd4,
    PH_WAIT  = 4'd5,
    PH_P04   = 4'd6,
    PH_REJ   = 4'd7,
    PH_DRAIN = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    ST_TAG   = 2'd0,
    ST_P04   = 2'd1,
    ST_NONE  = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_FOUR   = 8'h34;  // '4'
  localparam logic [7:0] CH_FILLER = 8'h46;  // 'F'
  localparam logic [7:0] CH_TERM   = 8'h3B;  // ';'
  localparam logic [7:0] TAG_RESET = 8'h05;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  // up to two results produced by one character
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### hdl/tbcd_core.sv
// Input register, header parser state and per-character result generation.
module tbcd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_ch_i,
  input  logic             in_last_i,
  input  logic             room_i,
  output tbcd_pkg::push_t  push_o
);
  import tbcd_pkg::*;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    return r;
  endfunction

  logic       vld_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       consume;
  logic [7:0] target_q;

  phase_e     phase_q, phase_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] tag_hi_q, tag_hi_d;
  logic       match_q, match_d;
  logic [7:0] len_q, len_d;
  logic [8:0] left_q, left_d, left_dec;
  logic [7:0] held_q, held_d;
  logic       odd_q, odd_d;
  logic       found_q, found_d;

  logic       term;
  logic [4:0] hv_c, hv_hi;
  push_t      push;
  logic [1:0] st;

  assign consume    = vld_q && room_i;
  assign in_ready_o = !vld_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q <= 1'b1;
    end else if (consume) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q   <= in_ch_i;
      last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TAG_RESET;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign term     = (ch_q == CH_TERM);
  assign hv_c     = hex_val(ch_q);
  assign hv_hi    = hex_val(tag_hi_q);
  assign left_dec = left_q - 9'd1;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    tag_hi_d = tag_hi_q;
    match_d  = match_q;
    len_d    = len_q;
    left_d   = left_q;
    held_d   = held_q;
    odd_d    = odd_q;
    found_d  = found_q;
    push     = '0;
    st       = ST_NONE;

    if (consume) begin
      if (phase_q == PH_DRAIN) begin
        if (last_q) begin
          phase_d  = PH_P0;
          pos_d    = '0;
          tag_hi_d = '0;
          match_d  = 1'b0;
          len_d    = '0;
          left_d   = '0;
          held_d   = '0;
          odd_d    = 1'b0;
          found_d  = 1'b0;
        end
      end else begin
        if (!term) begin
          case (phase_q)
            PH_P0: begin
              phase_d = (ch_q == CH_ZERO) ? PH_P1 : PH_REJ;
            end
            PH_P1: begin
              if (ch_q == CH_ZERO) begin
                phase_d = PH_REC;
                pos_d   = 2'd0;
              end else if (ch_q == CH_FOUR) begin
                phase_d = PH_P04;
                odd_d   = 1'b0;
              end else begin
                phase_d = PH_REJ;
              end
            end
            PH_REC: begin
              case (pos_q)
                2'd0: begin
                  tag_hi_d = ch_q;
                  pos_d    = 2'd1;
                end
                2'd1: begin
                  match_d = hv_hi[4] && hv_c[4] && (hv_hi[3:0] == target_q[7:4])
                            && (hv_c[3:0] == target_q[3:0]);
                  pos_d   = 2'd2;
                end
                2'd2: begin
                  len_d = {hv_c[4] ? hv_c[3:0] : 4'd0, 4'd0};
                  pos_d = 2'd3;
                end
                default: begin
                  len_d  = {len_q[7:4], hv_c[4] ? hv_c[3:0] : 4'd0};
                  left_d = {len_d, 1'b0};
                  pos_d  = 2'd0;
                  if (match_q) begin
                    odd_d   = 1'b0;
                    phase_d = (left_d == '0) ? PH_WAIT : PH_VAL;
                  end else if (left_d != '0) begin
                    phase_d = PH_SKIP;
                  end
                end
              endcase
            end
            PH_SKIP: begin
              left_d = left_dec;
              if (left_dec == '0) begin
                phase_d = PH_REC;
                pos_d   = 2'd0;
              end
            end
            PH_VAL: begin
              left_d = left_dec;
              if (!odd_q) begin
                held_d = ch_q;
                odd_d  = 1'b1;
              end else begin
                odd_d                = 1'b0;
                push.n               = 2'd1;
                push.r0.out_char     = ch_q;
                push.r0.char_valid   = 1'b1;
                push.r1.out_char     = held_q;
                push.r1.char_valid   = 1'b1;
                if (left_dec == '0) begin
                  // trailing filler digit is dropped
                  if (held_q != CH_FILLER) push.n = 2'd2;
                  found_d = 1'b1;
                  phase_d = PH_WAIT;
                end else begin
                  push.n = 2'd2;
                end
              end
            end
            PH_P04: begin
              if (!odd_q) begin
                odd_d = 1'b1;
              end else begin
                odd_d              = 1'b0;
                push.n             = 2'd1;
                push.r0.out_char   = ch_q;
                push.r0.char_valid = 1'b1;
                found_d            = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end

        if (term || last_q) begin
          case (phase_d)
            PH_VAL:  st = ST_SHORT;
            PH_WAIT: st = found_d ? ST_TAG : ST_NONE;
            PH_P04:  st = found_d ? ST_P04 : ST_NONE;
            default: st = ST_NONE;
          endcase
          if (push.n == 2'd0) begin
            push.n  = 2'd1;
            push.r0 = '0;
          end
          if (push.n == 2'd2) begin
            push.r1.done_res = 1'b1;
            push.r1.status   = st;
          end else begin
            push.r0.done_res = 1'b1;
            push.r0.status   = st;
          end
          phase_d  = (term && !last_q) ? PH_DRAIN : PH_P0;
          pos_d    = '0;
          tag_hi_d = '0;
          match_d  = 1'b0;
          len_d    = '0;
          left_d   = '0;
          held_d   = '0;
          odd_d    = 1'b0;
          found_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_P0;
      pos_q    <= '0;
      tag_hi_q <= '0;
      match_q  <= 1'b0;
      len_q    <= '0;
      left_q   <= '0;
      held_q   <= '0;
      odd_q    <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      tag_hi_q <= tag_hi_d;
      match_q  <= match_d;
      len_q    <= len_d;
      left_q   <= left_d;
      held_q   <= held_d;
      odd_q    <= odd_d;
      found_q  <= found_d;
    end
  end

  assign push_o = push;

  // a result without a character only ever carries the final status
  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0 && !push.r0.char_valid) |-> push.r0.done_res)
    else $error("result without character is not final");

  // once a status goes out the parser restarts or drains
  a_restart_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0 && (push.r0.done_res || push.r1.done_res))
    |=> (phase_q == PH_P0 || phase_q == PH_DRAIN))
    else $error("parser not restarted after final status");

  a_no_push_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !consume |-> push.n == 2'd0)
    else $error("results pushed without consuming a character");

endmodule

### hdl/tbcd_outq.sv
// Small result queue: up to two results in per cycle, one out when ready.
module tbcd_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbcd_pkg::push_t     push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tbcd_pkg::result_t   out_o
);
  import tbcd_pkg::*;

  result_t          mem [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem[rptr_q];
  // two free slots needed before the next character is decoded
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));

  assign wptr_d = wptr_q + QPtrW'(push_i.n);
  assign rptr_d = rptr_q + QPtrW'(pop);
  assign cnt_d  = cnt_q + QCntW'(push_i.n) - QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem[wptr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem[wptr_q + QPtrW'(1)] <= push_i.r1;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (cnt_q + QCntW'(push_i.n) <= QCntW'(QDepth)))
    else $error("push into full result queue");

endmodule

### hdl/uui_number_tbcd_decoder_unit.sv
// Top level of the TBCD user-to-user number decoder.
// Takes one header character per cycle on the slave stream unless stalled, and
// produces results on the master stream through its input register and queue.
// A character yields zero, one or two results; the 4-entry result queue drains
// one per cycle while m_axis_tready is high, so input stalls only while the
// queue has fewer than two free slots (runs of swapped digit pairs then settle
// at one character per cycle on average). The final result of a header has
// tlast set and carries the status in tuser; decoded digits are kept by the
// consumer only if that status is 0 or 1. target_tag resets to 5; the user
// writes it via cfg_we_i/cfg_wdata_i only while idle, which is not enforced.
module uui_number_tbcd_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,    // target_tag
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [2:0] m_axis_tuser,   // [0] char_valid, [2:1] status
  output logic       m_axis_tlast    // done_res
);
  import tbcd_pkg::*;

  push_t   push;
  logic    room;
  result_t res;

  tbcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_ch_i     (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .room_i      (room),
    .push_o      (push)
  );

  tbcd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = res.out_char;
  assign m_axis_tuser = {res.status, res.char_valid};
  assign m_axis_tlast = res.done_res;

endmodule
